[rtl/core/vrp_pkg.sv]
// shared constants, command and status types for the varispeed ring playback block
`default_nettype none
package vrp_pkg;

    localparam int BUFFER_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = ADDR_W + 16;
    localparam int DIV_STEPS    = 16;

    // pi in Q2.20
    localparam logic [21:0] PI_Q20        = 22'd3294199;
    localparam logic [15:0] VSMOOTH_RESET = 16'd66;
    localparam logic [23:0] VEL_ONE       = 24'h100000;

    typedef enum logic [1:0] {
        MUL_VEL  = 2'd0,
        MUL_HERM = 2'd1,
        MUL_LP   = 2'd2
    } mul_sel_t;

    typedef enum logic [1:0] {
        HC_C2 = 2'd0,
        HC_C1 = 2'd1,
        HC_C0 = 2'd2
    } herm_sel_t;

    typedef struct packed {
        logic      accept;
        logic      rec_wr;
        logic      rd_en;
        logic [1:0] rd_off;
        logic      tap_shift;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      vel_upd;
        logic      coef_load;
        logic      herm_add;
        herm_sel_t herm_sel;
        logic      raw_load;
        logic      div_load;
        logic      div_step;
        logic      lp_fast;
        logic      lp_slow;
        logic      pos_adv;
        logic      out_load;
    } vrp_cmd_t;

    typedef struct packed {
        logic fast;
        logic out_free;
    } vrp_stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
        logic signed [15:0] r;
        if (x > 32'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (x < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/vrp_if.sv]
// input and result channel interfaces
`default_nettype none
interface vrp_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] sample;
    logic signed [15:0] speed;
    modport source (output valid, output action, output sample, output speed,
                    input ready);
    modport sink (input valid, input action, input sample, input speed,
                  output ready);
endinterface

interface vrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic        [15:0] playhead;
    modport source (output valid, output out_sample, output playhead, input ready);
    modport sink (input valid, input out_sample, input playhead, output ready);
endinterface
`default_nettype wire

[rtl/core/varispeed_ring_playback_top.sv]
// top level of the varispeed ring playback block
//
// item channel: valid/ready; action 0 records sample into the ring at the
// write pointer, action 1 plays one sample at the requested speed (Q3.12).
// result channel: valid/ready; one transfer per play item carrying the
// interpolated, optionally low-passed sample and the integer playhead.
// cfg_we/cfg_wdata write the velocity smoothing coefficient (Q0.16).
// items are taken one at a time from the sequencer's idle state.
// a record item writes the ring in one state after acceptance. a play item
// makes four reads of the single ring read port and uses the shared
// multiplier for velocity and three interpolation passes; when the magnitude
// of the smoothed speed is above 1.0 it also runs the bit-serial alpha divider and a low-pass multiply.
// the result sits in an output register; while the receiver stalls, the
// finished item waits there and the next play item holds in its last step.
// reset clears pointers, position, velocity and low-pass state and sets the
// coefficient to 66; unwritten ring entries read as zero until the first
// wrap of the write pointer, so no clearing pass is needed.
`default_nettype none
module varispeed_ring_playback_top (
    input  logic          clk,
    input  logic          rst_n,
    vrp_in_if.sink        item,
    vrp_out_if.source     result,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);
    import vrp_pkg::*;

    vrp_cmd_t  cmd;
    vrp_stat_t stat;

    vrp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    vrp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .smp_in     (item.sample),
        .tgt_in     (item.speed),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_sample (result.out_sample),
        .playhead   (result.playhead)
    );

endmodule
`default_nettype wire

[rtl/core/vrp_ctrl.sv]
// sequencer that steps one record or play item through the datapath
`default_nettype none
module vrp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_action,
    output logic               item_ready,
    input  vrp_pkg::vrp_stat_t stat,
    output vrp_pkg::vrp_cmd_t  cmd
);
    import vrp_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_REC   = 16'h0002,
        S_T0    = 16'h0004,
        S_T1    = 16'h0008,
        S_T2    = 16'h0010,
        S_T3    = 16'h0020,
        S_T4    = 16'h0040,
        S_COEF  = 16'h0080,
        S_HMUL  = 16'h0100,
        S_HADD  = 16'h0200,
        S_RAW   = 16'h0400,
        S_DIV   = 16'h0800,
        S_LPMUL = 16'h1000,
        S_LPUPD = 16'h2000,
        S_ADV   = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_VEL;
        cmd.herm_sel = HC_C2;
        item_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = item_action ? S_T0 : S_REC;
                end
            end
            S_REC:
            begin
                cmd.rec_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_T0:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_off  = 2'd0;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_VEL;
                state_next  = S_T1;
            end
            S_T1:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_off    = 2'd1;
                cmd.tap_shift = 1'b1;
                cmd.vel_upd   = 1'b1;
                state_next    = S_T2;
            end
            S_T2:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_off    = 2'd2;
                cmd.tap_shift = 1'b1;
                state_next    = S_T3;
            end
            S_T3:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_off    = 2'd3;
                cmd.tap_shift = 1'b1;
                state_next    = S_T4;
            end
            S_T4:
            begin
                cmd.tap_shift = 1'b1;
                state_next    = S_COEF;
            end
            S_COEF:
            begin
                cmd.coef_load = 1'b1;
                cnt_next      = '0;
                state_next    = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HERM;
                state_next  = S_HADD;
            end
            S_HADD:
            begin
                cmd.herm_add = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    cmd.herm_sel = HC_C2;
                    2'd1:    cmd.herm_sel = HC_C1;
                    default: cmd.herm_sel = HC_C0;
                endcase
                if (cnt_reg[1:0] == 2'd2)
                begin
                    state_next = S_RAW;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_HMUL;
                end
            end
            S_RAW:
            begin
                cmd.raw_load = 1'b1;
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = stat.fast ? S_DIV : S_ADV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = S_LPMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_LPMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LP;
                state_next  = S_LPUPD;
            end
            S_LPUPD:
            begin
                cmd.lp_fast = 1'b1;
                state_next  = S_ADV;
            end
            S_ADV:
            begin
                cmd.pos_adv = 1'b1;
                cmd.lp_slow = !stat.fast;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/vrp_dp.sv]
// ring memory, shared multiplier, alpha divider and playback arithmetic
`default_nettype none
module vrp_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  vrp_pkg::vrp_cmd_t  cmd,
    output vrp_pkg::vrp_stat_t stat,
    input  logic signed [15:0] smp_in,
    input  logic signed [15:0] tgt_in,
    input  logic               cfg_we,
    input  logic        [15:0] cfg_wdata,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [15:0] out_sample,
    output logic        [15:0] playhead
);
    import vrp_pkg::*;

    localparam logic [ADDR_W+1:0] DEPTH_X = (ADDR_W+2)'(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(BUFFER_DEPTH - 1);
    localparam logic signed [POS_W+1:0] LIMIT = $signed((POS_W+2)'(BUFFER_DEPTH) << 16);

    logic signed [15:0] mem [0:BUFFER_DEPTH-1];
    logic signed [15:0] mem_q_reg;
    logic               rdv_reg;

    logic [ADDR_W-1:0]  wp_reg;
    logic               full_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic signed [23:0] v_reg;
    logic signed [15:0] lp_reg;
    logic [15:0]        coef_reg;
    logic               out_valid_reg;

    logic signed [15:0] smp_reg, tgt_reg;
    logic signed [15:0] tap_reg [4];
    logic signed [42:0] prod_reg;
    logic signed [21:0] acc_reg;
    logic signed [15:0] raw_reg;
    logic [23:0]        den_reg, rem_reg;
    logic [15:0]        lo_reg, q_reg;
    logic signed [15:0] out_sample_reg;
    logic [15:0]        playhead_reg;

    // tap address with wrap in both directions
    logic [ADDR_W+1:0] ta, tb, tc;
    logic [ADDR_W-1:0] rd_addr;
    always_comb
    begin
        ta = {2'b00, pos_reg[POS_W-1:16]} + (ADDR_W+2)'(cmd.rd_off);
        tb = (ta == '0) ? DEPTH_X : ta;
        tc = tb - (ADDR_W+2)'(1);
        if (tc >= DEPTH_X)
        begin
            tc = tc - DEPTH_X;
        end
        rd_addr = tc[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rec_wr)
        begin
            mem[wp_reg] <= smp_reg;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // entries past the write pointer before the first wrap still read as zero
    logic signed [15:0] tap_in;
    assign tap_in = rdv_reg ? mem_q_reg : 16'sd0;

    // velocity and magnitude
    logic signed [24:0] diff;
    logic [23:0]        absv;
    assign diff = $signed({tgt_reg[15], tgt_reg, 8'd0}) - $signed({v_reg[23], v_reg});
    assign absv = v_reg[23] ? 24'(-v_reg) : v_reg;
    assign stat.fast     = absv > VEL_ONE;
    assign stat.out_free = !out_valid_reg || out_ready;

    // hermite coefficients, doubled
    logic signed [20:0] em1, e0, e1, e2, c1, c2, c3, c0, csel;
    always_comb
    begin
        em1 = 21'(tap_reg[3]);
        e0  = 21'(tap_reg[2]);
        e1  = 21'(tap_reg[1]);
        e2  = 21'(tap_reg[0]);
        c0  = e0 <<< 1;
        c1  = e1 - em1;
        c2  = (em1 <<< 1) - ((e0 <<< 2) + e0) + (e1 <<< 2) - e2;
        c3  = (e2 - em1) + (((e0 - e1) <<< 1) + (e0 - e1));
        case (cmd.herm_sel)
            HC_C2:   csel = c2;
            HC_C1:   csel = c1;
            HC_C0:   csel = c0;
            default: csel = c0;
        endcase
    end

    // shared multiplier operands
    logic signed [25:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [16:0] lp_diff;
    assign lp_diff = $signed({raw_reg[15], raw_reg}) - $signed({lp_reg[15], lp_reg});
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_VEL:
            begin
                mul_a = 26'(diff);
                mul_b = $signed({1'b0, coef_reg});
            end
            MUL_HERM:
            begin
                mul_a = 26'(acc_reg);
                mul_b = $signed({1'b0, pos_reg[15:0]});
            end
            MUL_LP:
            begin
                mul_a = 26'(lp_diff);
                mul_b = $signed({1'b0, q_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [42:0] prod_rs;
    logic signed [26:0] prod_r;
    assign prod_rs = (prod_reg + 43'sd32768) >>> 16;
    assign prod_r  = prod_rs[26:0];

    logic signed [26:0] v_sum, h_sum;
    logic signed [21:0] acc_rnd;
    logic signed [15:0] raw_next;
    logic signed [26:0] lpf_sum;
    logic signed [17:0] lps_half;
    logic signed [17:0] lps_sum;
    assign v_sum    = 27'(v_reg) + prod_r;
    assign h_sum    = prod_r + 27'(csel);
    assign acc_rnd  = (acc_reg + 22'sd1) >>> 1;
    assign raw_next = sat16(32'(acc_rnd));
    assign lpf_sum  = 27'(lp_reg) + prod_r;
    assign lps_half = (18'(lp_diff) + 18'sd1) >>> 1;
    assign lps_sum  = 18'(lp_reg) + lps_half;

    // divider for alpha, one quotient bit per step
    logic [23:0] den_next;
    logic [37:0] num_next;
    logic [24:0] dtrial;
    logic        dge;
    assign den_next = absv + 24'(PI_Q20);
    assign num_next = {PI_Q20, 16'd0} + 38'(den_next >> 1);
    assign dtrial   = {rem_reg, lo_reg[15]};
    assign dge      = dtrial >= {1'b0, den_reg};

    // read position advance with wrap
    logic signed [19:0]      adv;
    logic signed [POS_W+1:0] np;
    always_comb
    begin
        adv = 20'(v_reg >>> 4);
        np  = $signed({2'b00, pos_reg}) + (POS_W+2)'(adv);
        if (np < 0)
        begin
            np = np + LIMIT;
        end
        else if (np >= LIMIT)
        begin
            np = np - LIMIT;
        end
        pos_next = np[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            pos_reg       <= '0;
            v_reg         <= '0;
            lp_reg        <= '0;
            coef_reg      <= VSMOOTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                coef_reg <= cfg_wdata;
            end
            if (cmd.rec_wr)
            begin
                if (wp_reg == LAST_A)
                begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + ADDR_W'(1);
                end
            end
            if (cmd.vel_upd)
            begin
                v_reg <= v_sum[23:0];
            end
            if (cmd.lp_fast)
            begin
                lp_reg <= sat16(32'(lpf_sum));
            end
            else if (cmd.lp_slow)
            begin
                lp_reg <= sat16(32'(lps_sum));
            end
            if (cmd.pos_adv)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg <= smp_in;
            tgt_reg <= tgt_in;
        end
        if (cmd.rd_en)
        begin
            rdv_reg <= full_reg || (rd_addr < wp_reg);
        end
        if (cmd.tap_shift)
        begin
            tap_reg[0] <= tap_in;
            tap_reg[1] <= tap_reg[0];
            tap_reg[2] <= tap_reg[1];
            tap_reg[3] <= tap_reg[2];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= 43'(mul_a) * 43'(mul_b);
        end
        if (cmd.coef_load)
        begin
            acc_reg <= 22'(c3);
        end
        else if (cmd.herm_add)
        begin
            acc_reg <= h_sum[21:0];
        end
        if (cmd.raw_load)
        begin
            raw_reg <= raw_next;
        end
        if (cmd.div_load)
        begin
            den_reg <= den_next;
            rem_reg <= 24'(num_next[37:16]);
            lo_reg  <= num_next[15:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= dge ? 24'(dtrial - {1'b0, den_reg}) : dtrial[23:0];
            lo_reg  <= {lo_reg[14:0], 1'b0};
            q_reg   <= {q_reg[14:0], dge};
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= stat.fast ? lp_reg : raw_reg;
            playhead_reg   <= 16'(pos_reg[POS_W-1:16]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign playhead   = playhead_reg;

endmodule
`default_nettype wire

[test/varispeed_ring_playback_top_tb.sv]
// testbench for the varispeed ring playback block: directed and random items against a predictor
`timescale 1ns / 1ps
module varispeed_ring_playback_top_tb;
    import vrp_pkg::*;

    localparam int DEPTH = 65536;
    localparam longint PIQ = 3294199;
    localparam logic ACT_REC = 1'b0;
    localparam logic ACT_PLAY = 1'b1;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic [15:0] playhead;
    } play_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    vrp_in_if item ();
    vrp_out_if result ();

    varispeed_ring_playback_top DUT (
        .clk(clk), .rst_n(rst_n), .item(item.sink), .result(result.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] ring [DEPTH];
    logic [15:0] wr_ptr;
    longint rd_pos;
    longint vel;
    longint lp;
    longint coef;

    play_result_t pending_q [$];
    int errors = 0;
    int n_rec = 0;
    int n_play = 0;
    int n_fast = 0;
    longint cycles = 0;

    function automatic longint asr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint rshift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(longint x);
        if (x > 32767)
        begin
            return 32767;
        end
        else if (x < -32768)
        begin
            return -32768;
        end
        return x;
    endfunction

    function automatic longint ring_at(longint base, int off);
        return longint'(ring[16'((base + off + DEPTH) % DEPTH)]);
    endfunction

    function automatic longint interp(longint pos);
        longint i0, f, ym1, y0, y1, y2, c0, c1, c2, c3, acc;
        i0 = pos >> 16;
        f = pos & 64'hFFFF;
        ym1 = ring_at(i0, -1);
        y0 = ring_at(i0, 0);
        y1 = ring_at(i0, 1);
        y2 = ring_at(i0, 2);
        c0 = 2 * y0;
        c1 = y1 - ym1;
        c2 = 2 * ym1 - 5 * y0 + 4 * y1 - y2;
        c3 = (y2 - ym1) + 3 * (y0 - y1);
        acc = c3;
        acc = rshift(acc * f, 16) + c2;
        acc = rshift(acc * f, 16) + c1;
        acc = rshift(acc * f, 16) + c0;
        return clip16(rshift(acc, 1));
    endfunction

    task automatic predict_playback(input logic act, input logic signed [15:0] smp,
                                    input logic signed [15:0] tv);
        longint diff, raw, absv, den, alpha, outv, np, lim;
        play_result_t r;
        lim = longint'(DEPTH) << 16;
        if (act == ACT_REC)
        begin
            ring[wr_ptr] = smp;
            wr_ptr = wr_ptr + 16'd1;
            n_rec++;
            return;
        end
        diff = longint'(tv) * 256 - vel;
        vel = vel + rshift(diff * coef, 16);
        raw = interp(rd_pos);
        absv = (vel < 0) ? -vel : vel;
        if (absv > (longint'(1) << 20))
        begin
            den = absv + PIQ;
            alpha = ((PIQ << 16) + den / 2) / den;
            lp = clip16(lp + rshift(alpha * (raw - lp), 16));
            outv = lp;
            n_fast++;
        end
        else
        begin
            lp = clip16(lp + rshift(raw - lp, 1));
            outv = raw;
        end
        np = (rd_pos % lim) + asr(vel, 4);
        if (np < 0)
        begin
            np += lim;
        end
        else if (np >= lim)
        begin
            np -= lim;
        end
        rd_pos = np;
        r.out_sample = outv[15:0];
        r.playhead = rd_pos[31:16];
        pending_q.push_back(r);
        n_play++;
    endtask

    // valid stays high after a transfer until the next gap or drain
    task automatic send_item(input logic act, input logic signed [15:0] smp,
                             input logic signed [15:0] tv);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.action <= act;
        item.sample <= smp;
        item.speed <= tv;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        predict_playback(act, smp, tv);
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_smoothing(input logic [15:0] c);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        coef = longint'(c);
    endtask

    // result checker with random receiver stalls
    initial
    begin
        play_result_t e;
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
            if (pending_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (result.out_sample !== e.out_sample)
                begin
                    $error("out_sample expected %0d actual %0d", e.out_sample,
                           result.out_sample);
                    errors++;
                end
                if (result.playhead !== e.playhead)
                begin
                    $error("playhead expected %0d actual %0d", e.playhead, result.playhead);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("varispeed_ring_playback_top_tb: errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(ACT_PLAY, 16'sd0, 16'sd0);
        send_item(ACT_REC, 16'sh7fff, 16'sd0);
        send_item(ACT_REC, 16'sh8000, 16'sd0);
        send_item(ACT_REC, 16'sh7fff, 16'sd0);
        send_item(ACT_REC, 16'sh8000, 16'sd0);
        send_item(ACT_REC, 16'sh7fff, 16'sh7fff);
        send_item(ACT_PLAY, 16'sd0, 16'sd4096);   // exactly unity speed
        send_item(ACT_PLAY, 16'sd0, 16'sh7fff);
        send_item(ACT_PLAY, 16'sd0, 16'sh8000);
        send_item(ACT_PLAY, 16'sd0, -16'sd4096);
        send_item(ACT_PLAY, 16'sd0, 16'sd4097);
        send_item(ACT_PLAY, 16'shffff, -16'sd2048);
    endtask

    task automatic test_coef_extremes();
        write_smoothing(16'hffff);
        send_item(ACT_PLAY, 16'sd0, 16'sd4096);
        send_item(ACT_PLAY, 16'sd0, 16'sd4096);    // lands on unity, slow branch
        send_item(ACT_PLAY, 16'sd0, 16'sh7fff);    // overshoot on alternating data
        send_item(ACT_PLAY, 16'sd0, 16'sh8000);    // backward wrap through zero
        send_item(ACT_PLAY, 16'sd0, 16'sd4097);
        write_smoothing(16'h0000);
        send_item(ACT_PLAY, 16'sd0, 16'sh7fff);
        send_item(ACT_PLAY, 16'sd0, 16'sh8000);
    endtask

    task automatic test_random(input int count);
        int k, kind;
        logic signed [15:0] tv;
        for (k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                tv = 16'($urandom);
                send_item(ACT_REC, 16'($urandom), tv);
            end
            else
            begin
                if (kind < 7)
                begin
                    tv = 16'($urandom_range(0, 16384) - 8192);
                end
                else
                begin
                    tv = 16'($urandom);
                end
                send_item(ACT_PLAY, 16'($urandom), tv);
            end
            if (k == count / 2)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            ring[i] = 16'sd0;
        end
        wr_ptr = 16'd0;
        rd_pos = 0;
        vel = 0;
        lp = 0;
        coef = 66;
        item.valid = 1'b0;
        item.action = ACT_REC;
        item.sample = 16'sd0;
        item.speed = 16'sd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_coef_extremes();
        write_smoothing(16'd8000);
        test_random(400);
        write_smoothing(16'd66);
        test_random(400);
        write_smoothing(16'hffff);
        test_random(400);
        wait_drained();
        $display("covered %0d record and %0d play items, %0d on the low-pass path",
                 n_rec, n_play, n_fast);
        $display("smoothing coefficient set to 0, 66, 8000 and 65535");
        if (errors == 0)
        begin
            $display("varispeed_ring_playback_top_tb: clean");
        end
        else
        begin
            $display("varispeed_ring_playback_top_tb: errors");
        end
        $finish;
    end
endmodule
